// ===== rtl/core/audio_jitter_ring_with_gain_unit_assert.svh =====
// Assertion macros shared by the audio jitter ring RTL.
// Included by modules that carry concurrent checks; no other dependencies.
`ifndef AUDIO_JITTER_RING_WITH_GAIN_UNIT_ASSERT_SVH
`define AUDIO_JITTER_RING_WITH_GAIN_UNIT_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted
`define AJR_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted
`define AJR_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/core/ajr_pkg.sv =====
// Package for the audio jitter ring: widths, register indexes, item kinds,
// shared structs and the back-end state type. No dependencies.
`timescale 1ns / 1ps

package ajr_pkg;

    // Ring geometry
    localparam int RING_DEPTH = 262144;
    localparam int IDX_W      = $clog2(RING_DEPTH);
    localparam int FILL_W     = $clog2(RING_DEPTH + 1);

    // Field widths
    localparam int FUNC_W     = 2;
    localparam int BYTE_W     = 8;
    localparam int SAMPLE_W   = 16;
    localparam int LEVEL_W    = 19;
    localparam int GAIN_W     = 16;
    localparam int IDLE_W     = 16;
    localparam int MARGIN_W   = 19;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 19;

    // Queue between front and back
    localparam int QDEPTH     = 2;
    localparam int QPTR_W     = $clog2(QDEPTH);
    localparam int QCNT_W     = $clog2(QDEPTH + 1);

    // Constants
    localparam logic [GAIN_W-1:0]   GAIN_RESET   = 16'd16384;
    localparam logic [GAIN_W-1:0]   GAIN_MAX     = 16'd32768;
    localparam logic [IDLE_W-1:0]   IDLE_RESET   = 16'd3000;
    localparam logic [IDLE_W-1:0]   QUIET_MAX    = 16'hFFFF;
    localparam logic [MARGIN_W-1:0] MARGIN_RESET = 19'd2048;
    localparam logic [SAMPLE_W-1:0] KEEPALIVE    = 16'd5;
    localparam int                  GAIN_SHIFT   = 14;

    // Input function codes
    localparam logic [FUNC_W-1:0] FUNC_PUSH = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_POP  = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_TICK = 2'd2;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_GAIN   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_IDLE   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MARGIN = 2'd2;

    typedef enum logic [1:0] {
        K_STAT,
        K_FRAME,
        K_POP
    } t_kind;

    typedef enum logic [1:0] {
        B_IDLE,
        B_WR2,
        B_READ,
        B_MUL
    } t_back_state;

    typedef struct packed {
        logic [GAIN_W-1:0]   gain_q14;
        logic [IDLE_W-1:0]   idle_limit_ms;
        logic [MARGIN_W-1:0] room_margin;
    } t_cfg;

    typedef struct packed {
        t_kind               kind;
        logic [SAMPLE_W-1:0] left;
        logic [SAMPLE_W-1:0] right;
        logic                block_end;
        logic                receiving;
    } t_entry;

endpackage

// ===== rtl/core/ajr_in_if.sv =====
// Input channel interface: valid/ready handshake with the item fields.
// Depends on ajr_pkg for field widths.
`timescale 1ns / 1ps

interface ajr_in_if;
    import ajr_pkg::*;

    logic              valid;
    logic              ready;
    logic [FUNC_W-1:0] func;
    logic [BYTE_W-1:0] data_byte;
    logic              block_end;

    modport source (output valid, output func, output data_byte, output block_end,
                    input ready);
    modport sink   (input valid, input func, input data_byte, input block_end,
                    output ready);
endinterface

// ===== rtl/core/ajr_out_if.sv =====
// Result channel interface: valid/ready handshake with the result fields.
// Depends on ajr_pkg for field widths.
`timescale 1ns / 1ps

interface ajr_out_if;
    import ajr_pkg::*;

    logic                       valid;
    logic                       ready;
    logic signed [SAMPLE_W-1:0] sample_out;
    logic                       sample_from_ring;
    logic [LEVEL_W-1:0]         fill_level;
    logic                       room_low;
    logic                       receiving;

    modport source (output valid, output sample_out, output sample_from_ring,
                    output fill_level, output room_low, output receiving,
                    input ready);
    modport sink   (input valid, input sample_out, input sample_from_ring,
                    input fill_level, input room_low, input receiving,
                    output ready);
endinterface

// ===== rtl/core/ajr_front.sv =====
// Front end: accepts items, assembles stereo frames from bytes, tracks idle time.
// Depends on ajr_pkg and ajr_in_if; feeds ajr_queue.
`timescale 1ns / 1ps

module ajr_front (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  ajr_pkg::t_cfg   i_cfg,
    ajr_in_if.sink          i_in,
    input  logic            i_q_full,
    output logic            o_q_push,
    output ajr_pkg::t_entry o_q_entry
);
    import ajr_pkg::*;

    logic [23:0]       r_held;
    logic [1:0]        r_held_cnt;
    logic [IDLE_W-1:0] r_quiet;
    logic              r_recv;

    logic [23:0]       n_held;
    logic [1:0]        n_held_cnt;
    logic [IDLE_W-1:0] n_quiet;
    logic              n_recv;
    logic              accept;

    assign i_in.ready = !i_q_full;
    assign accept     = i_in.valid && !i_q_full;
    assign o_q_push   = accept;

    // Classify the item and compute the front state after it
    always_comb begin
        n_held               = r_held;
        n_held_cnt           = r_held_cnt;
        n_quiet              = r_quiet;
        n_recv               = r_recv;
        o_q_entry.kind       = K_STAT;
        o_q_entry.left       = r_held[15:0];
        o_q_entry.right      = {i_in.data_byte, r_held[23:16]};
        o_q_entry.block_end  = i_in.block_end;
        case (i_in.func)
            FUNC_PUSH: begin
                case (r_held_cnt)
                    2'd0: n_held[7:0]   = i_in.data_byte;
                    2'd1: n_held[15:8]  = i_in.data_byte;
                    2'd2: n_held[23:16] = i_in.data_byte;
                    default: begin
                        o_q_entry.kind = K_FRAME;
                        n_held         = '0;
                    end
                endcase
                n_held_cnt = (r_held_cnt == 2'd3) ? 2'd0 : r_held_cnt + 2'd1;
                n_quiet    = '0;
                n_recv     = 1'b1;
            end
            FUNC_POP: begin
                o_q_entry.kind = K_POP;
            end
            FUNC_TICK: begin
                if (r_quiet != QUIET_MAX) begin
                    n_quiet = r_quiet + IDLE_W'(1);
                end
                if (r_recv && (n_quiet > i_cfg.idle_limit_ms)) begin
                    n_recv = 1'b0;
                end
            end
            default: begin
                o_q_entry.kind = K_STAT;
            end
        endcase
        o_q_entry.receiving = n_recv;
    end

    // Advance front state on each accepted transaction
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_held     <= '0;
            r_held_cnt <= '0;
            r_quiet    <= '0;
            r_recv     <= 1'b0;
        end else if (accept) begin
            r_held     <= n_held;
            r_held_cnt <= n_held_cnt;
            r_quiet    <= n_quiet;
            r_recv     <= n_recv;
        end
    end

endmodule

// ===== rtl/core/ajr_queue.sv =====
// Short FIFO of classified items between the front and back ends.
// Depends on ajr_pkg for the entry struct and depth.
`timescale 1ns / 1ps

module ajr_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  ajr_pkg::t_entry i_entry,
    input  logic            i_pop,
    output logic            o_valid,
    output logic            o_full,
    output ajr_pkg::t_entry o_entry
);
    import ajr_pkg::*;

    t_entry            r_slot [QDEPTH];
    logic [QPTR_W-1:0] r_wr_ptr;
    logic [QPTR_W-1:0] r_rd_ptr;
    logic [QCNT_W-1:0] r_count;

    logic do_push;
    logic do_pop;

    assign o_valid = (r_count != '0);
    assign o_full  = (r_count == QCNT_W'(QDEPTH));
    assign o_entry = r_slot[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    // Store pushed entries
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_slot[r_wr_ptr] <= i_entry;
        end
    end

    // Advance pointers and occupancy
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= (r_wr_ptr == QPTR_W'(QDEPTH - 1)) ? '0 : r_wr_ptr + QPTR_W'(1);
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == QPTR_W'(QDEPTH - 1)) ? '0 : r_rd_ptr + QPTR_W'(1);
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + QCNT_W'(1);
            end else if (do_pop && !do_push) begin
                r_count <= r_count - QCNT_W'(1);
            end
        end
    end

endmodule

// ===== rtl/core/ajr_back.sv =====
// Back end: sample ring memory, overwrite-on-full bookkeeping, gain and result register.
// Depends on ajr_pkg, ajr_out_if and the assertion macro header.
`timescale 1ns / 1ps
`include "audio_jitter_ring_with_gain_unit_assert.svh"

module ajr_back (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  ajr_pkg::t_cfg   i_cfg,
    input  logic            i_q_valid,
    input  ajr_pkg::t_entry i_q_entry,
    output logic            o_q_pop,
    ajr_out_if.source       o_out
);
    import ajr_pkg::*;

    function automatic logic [IDX_W-1:0] idx_inc(input logic [IDX_W-1:0] v);
        idx_inc = (v == IDX_W'(RING_DEPTH - 1)) ? '0 : v + IDX_W'(1);
    endfunction

    // Ring storage
    logic [SAMPLE_W-1:0] r_ring [RING_DEPTH];
    logic [SAMPLE_W-1:0] r_rd_data;

    t_back_state         r_state;
    t_back_state         n_state;
    logic [IDX_W-1:0]    r_wr_idx;
    logic [IDX_W-1:0]    r_rd_idx;
    logic [FILL_W-1:0]   r_fill;
    logic [IDX_W-1:0]    n_wr_idx;
    logic [IDX_W-1:0]    n_rd_idx;
    logic [FILL_W-1:0]   n_fill;

    // Latched item fields
    logic [SAMPLE_W-1:0] r_right;
    logic                r_last;
    logic                r_recv;

    logic signed [31:0]  r_prod;
    logic signed [31:0]  scaled;
    logic [SAMPLE_W-1:0] sat;
    logic [GAIN_W-1:0]   gain_clamp;
    logic signed [16:0]  gain_s;

    // Result register
    logic                       r_out_valid;
    logic signed [SAMPLE_W-1:0] r_out_sample;
    logic                       r_out_from;
    logic [LEVEL_W-1:0]         r_out_level;
    logic                       r_out_room;
    logic                       r_out_recv;

    logic                out_free;
    logic                start;
    logic                full;
    logic                mem_we;
    logic [SAMPLE_W-1:0] mem_wdata;
    logic                put;
    logic                take;
    logic                emit;
    logic [SAMPLE_W-1:0] emit_sample;
    logic                emit_from;
    logic                emit_recv;

    assign out_free = !r_out_valid || o_out.ready;
    assign start    = (r_state == B_IDLE) && i_q_valid && out_free;
    assign full     = (r_fill >= FILL_W'(RING_DEPTH));

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            B_IDLE: begin
                if (start) begin
                    case (i_q_entry.kind)
                        K_FRAME: n_state = B_WR2;
                        K_POP:   n_state = (r_fill != '0) ? B_READ : B_IDLE;
                        default: n_state = B_IDLE;
                    endcase
                end
            end
            B_WR2:   n_state = B_IDLE;
            B_READ:  n_state = B_MUL;
            B_MUL:   n_state = B_IDLE;
            default: n_state = B_IDLE;
        endcase
    end

    // Control outputs per state
    always_comb begin
        o_q_pop     = 1'b0;
        mem_we      = 1'b0;
        mem_wdata   = i_q_entry.left;
        put         = 1'b0;
        take        = 1'b0;
        emit        = 1'b0;
        emit_sample = '0;
        emit_from   = 1'b0;
        emit_recv   = r_recv;
        case (r_state)
            B_IDLE: begin
                emit_recv = i_q_entry.receiving;
                if (start) begin
                    o_q_pop = 1'b1;
                    case (i_q_entry.kind)
                        K_FRAME: begin
                            mem_we = 1'b1;
                            put    = 1'b1;
                        end
                        K_POP: begin
                            if (r_fill != '0) begin
                                take = 1'b1;
                            end else begin
                                emit        = 1'b1;
                                emit_sample = i_q_entry.block_end ? KEEPALIVE : '0;
                            end
                        end
                        default: emit = 1'b1;
                    endcase
                end
            end
            B_WR2: begin
                mem_we    = 1'b1;
                mem_wdata = r_right;
                put       = 1'b1;
                emit      = 1'b1;
            end
            B_MUL: begin
                emit        = 1'b1;
                emit_from   = 1'b1;
                emit_sample = r_last ? (sat | KEEPALIVE) : sat;
            end
            default: begin
                emit = 1'b0;
            end
        endcase
    end

    // Ring indexes and fill after this cycle
    always_comb begin
        n_wr_idx = r_wr_idx;
        n_rd_idx = r_rd_idx;
        n_fill   = r_fill;
        if (put) begin
            n_wr_idx = idx_inc(r_wr_idx);
            if (full) begin
                n_rd_idx = idx_inc(r_rd_idx);
            end else begin
                n_fill = r_fill + FILL_W'(1);
            end
        end else if (take) begin
            n_rd_idx = idx_inc(r_rd_idx);
            n_fill   = r_fill - FILL_W'(1);
        end
    end

    // Gain: clamp, then divide by 2^14 toward zero and saturate
    assign gain_clamp = (i_cfg.gain_q14 > GAIN_MAX) ? GAIN_MAX : i_cfg.gain_q14;
    assign gain_s     = {1'b0, gain_clamp};
    assign scaled     = (r_prod + (r_prod[31] ? 32'sd16383 : 32'sd0)) >>> GAIN_SHIFT;
    always_comb begin
        if (scaled > 32'sd32767) begin
            sat = 16'h7FFF;
        end else if (scaled < -32'sd32768) begin
            sat = 16'h8000;
        end else begin
            sat = scaled[SAMPLE_W-1:0];
        end
    end

    // Memory write port and registered read port
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_ring[r_wr_idx] <= mem_wdata;
        end
        r_rd_data <= r_ring[r_rd_idx];
    end

    // Datapath registers
    always_ff @(posedge i_clk) begin
        r_prod <= 32'($signed(r_rd_data)) * 32'(gain_s);
        if (o_q_pop) begin
            r_right <= i_q_entry.right;
            r_last  <= i_q_entry.block_end;
            r_recv  <= i_q_entry.receiving;
        end
        if (emit) begin
            r_out_sample <= emit_sample;
            r_out_from   <= emit_from;
            r_out_level  <= LEVEL_W'(n_fill);
            r_out_room   <= (32'(n_fill) + 32'(i_cfg.room_margin)) >= 32'(RING_DEPTH);
            r_out_recv   <= emit_recv;
        end
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= B_IDLE;
            r_wr_idx    <= '0;
            r_rd_idx    <= '0;
            r_fill      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_wr_idx <= n_wr_idx;
            r_rd_idx <= n_rd_idx;
            r_fill   <= n_fill;
            if (emit) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_out.valid            = r_out_valid;
    assign o_out.sample_out       = r_out_sample;
    assign o_out.sample_from_ring = r_out_from;
    assign o_out.fill_level       = r_out_level;
    assign o_out.room_low         = r_out_room;
    assign o_out.receiving        = r_out_recv;

    // Checks
    `AJR_ASSERT_IMP(a_fill_bound, i_clk, i_rst_n, 1'b1, r_fill <= FILL_W'(RING_DEPTH), "fill above ring depth")
    `AJR_ASSERT_IMP(a_slot_free, i_clk, i_rst_n, (r_state == B_WR2) || (r_state == B_MUL), !r_out_valid, "result slot busy at emit")
    `AJR_ASSERT_NXT(a_take_dec, i_clk, i_rst_n, take, r_fill == $past(r_fill) - FILL_W'(1), "pop did not lower fill")
    `AJR_ASSERT_NXT(a_full_hold, i_clk, i_rst_n, put && full, r_fill == FILL_W'(RING_DEPTH), "overwrite changed fill")

endmodule

// ===== rtl/core/audio_jitter_ring_with_gain_unit.sv =====
// Channel      | Dir | Handshake      | Payload
// i_in         | in  | valid/ready    | func, data_byte, block_end
// o_out        | out | valid/ready    | sample_out, sample_from_ring, fill_level, room_low, receiving
// i_cfg_*      | in  | write enable   | i_cfg_idx selects register, i_cfg_data is the value
//
// One result per item. Status items (byte, tick, empty pop) finish in the back-end idle state;
// a completed frame passes the idle and write states (one ring write per sample, single write port);
// a pop with data passes idle, read and multiply (registered memory read, multiply, scale, saturate).
// A 2-entry queue lets the front keep accepting while the back works or the result stalls.
// Reset is synchronous and active low; ring contents are not cleared, no clearing pass.
//
// Top level of the audio jitter ring; holds the configuration registers.
// Depends on ajr_pkg, ajr_in_if, ajr_out_if, ajr_front, ajr_queue, ajr_back.
`timescale 1ns / 1ps

module audio_jitter_ring_with_gain_unit (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    ajr_in_if.sink                          i_in,
    ajr_out_if.source                       o_out,
    input  logic                            i_cfg_we,
    input  logic [ajr_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [ajr_pkg::CFG_DATA_W-1:0]  i_cfg_data
);
    import ajr_pkg::*;

    t_cfg   r_cfg;
    logic   q_push;
    logic   q_pop;
    logic   q_valid;
    logic   q_full;
    t_entry q_in_entry;
    t_entry q_out_entry;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.gain_q14      <= GAIN_RESET;
            r_cfg.idle_limit_ms <= IDLE_RESET;
            r_cfg.room_margin   <= MARGIN_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_GAIN:   r_cfg.gain_q14      <= i_cfg_data[GAIN_W-1:0];
                CFG_IDLE:   r_cfg.idle_limit_ms <= i_cfg_data[IDLE_W-1:0];
                CFG_MARGIN: r_cfg.room_margin   <= i_cfg_data[MARGIN_W-1:0];
                default:    r_cfg <= r_cfg;
            endcase
        end
    end

    ajr_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg     (r_cfg),
        .i_in      (i_in),
        .i_q_full  (q_full),
        .o_q_push  (q_push),
        .o_q_entry (q_in_entry)
    );

    ajr_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_entry (q_in_entry),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_full  (q_full),
        .o_entry (q_out_entry)
    );

    ajr_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg     (r_cfg),
        .i_q_valid (q_valid),
        .i_q_entry (q_out_entry),
        .o_q_pop   (q_pop),
        .o_out     (o_out)
    );

endmodule

// ===== dv/ajr_ring_checker.sv =====
// Checker for the audio jitter ring: watches the item and result channels
// and the register port, predicts each result and compares it field by field.
// Depends on ajr_pkg, ajr_in_if and ajr_out_if.
`timescale 1ns / 1ps

module ajr_ring_checker (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    ajr_in_if                              i_in_mon,
    ajr_out_if                             i_out_mon,
    input  logic                           i_cfg_we,
    input  logic [ajr_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [ajr_pkg::CFG_DATA_W-1:0] i_cfg_data,
    output int                             o_fail_count,
    output int                             o_pending
);
    import ajr_pkg::*;

    typedef struct packed {
        logic [SAMPLE_W-1:0] sample_out;
        logic                from_ring;
        logic [LEVEL_W-1:0]  fill_level;
        logic                room_low;
        logic                receiving;
    } t_ring_status;

    // Shadow of the ring contents: oldest sample at the front
    logic [SAMPLE_W-1:0] shadow_ring[$];
    logic [23:0]         held_bytes;
    logic [1:0]          held_cnt;
    logic [IDLE_W-1:0]   quiet_ms;
    logic                receiving;

    // Shadow of the configuration registers
    logic [GAIN_W-1:0]   gain_q14;
    logic [IDLE_W-1:0]   idle_limit;
    logic [MARGIN_W-1:0] room_margin;

    t_ring_status status_due[$];

    // Multiply by the clamped unsigned Q2.14 gain, truncate toward zero, saturate
    function automatic logic [SAMPLE_W-1:0] scale_sample(logic [SAMPLE_W-1:0] raw);
        longint g;
        longint prod;
        g    = (gain_q14 > GAIN_MAX) ? longint'(GAIN_MAX) : longint'(gain_q14);
        prod = (longint'($signed(raw)) * g) / (longint'(1) << GAIN_SHIFT);
        if (prod > 32767)
            prod = 32767;
        else if (prod < -32768)
            prod = -32768;
        return prod[SAMPLE_W-1:0];
    endfunction

    // Advance the ring state by one transaction and return its status
    function automatic t_ring_status step_ring_model(logic [FUNC_W-1:0] f,
                                                     logic [BYTE_W-1:0] b,
                                                     logic blk);
        t_ring_status        res;
        logic [SAMPLE_W-1:0] frame[2];
        logic [SAMPLE_W-1:0] raw;
        res = '0;
        case (f)
            FUNC_PUSH: begin
                if (held_cnt < 2'd3) begin
                    held_bytes[held_cnt*8 +: 8] = b;
                    held_cnt++;
                end else begin
                    frame[0] = held_bytes[15:0];
                    frame[1] = {b, held_bytes[23:16]};
                    // a full ring drops its oldest sample
                    for (int k = 0; k < 2; k++) begin
                        shadow_ring.push_back(frame[k]);
                        if (shadow_ring.size() > RING_DEPTH)
                            void'(shadow_ring.pop_front());
                    end
                    held_bytes = '0;
                    held_cnt   = '0;
                end
                quiet_ms  = '0;
                receiving = 1'b1;
            end
            FUNC_POP: begin
                if (shadow_ring.size() > 0) begin
                    raw           = shadow_ring.pop_front();
                    res.sample_out = scale_sample(raw);
                    res.from_ring = 1'b1;
                end
                if (blk)
                    res.sample_out = res.sample_out | KEEPALIVE;
            end
            FUNC_TICK: begin
                if (quiet_ms != QUIET_MAX)
                    quiet_ms++;
                if (receiving && quiet_ms > idle_limit)
                    receiving = 1'b0;
            end
            default: ;
        endcase
        res.fill_level = LEVEL_W'(shadow_ring.size());
        res.room_low   = (longint'(shadow_ring.size()) + longint'(room_margin))
                         >= longint'(RING_DEPTH);
        res.receiving  = receiving;
        return res;
    endfunction

    task automatic check_field(string name, longint want, longint got);
        if (want != got) begin
            o_fail_count++;
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
        end
    endtask

    // Compare results, track register writes, then predict new transactions
    always @(posedge i_clk) begin
        t_ring_status want;
        if (!i_rst_n) begin
            shadow_ring.delete();
            status_due.delete();
            held_bytes  = '0;
            held_cnt    = '0;
            quiet_ms    = '0;
            receiving   = 1'b0;
            gain_q14    = GAIN_RESET;
            idle_limit  = IDLE_RESET;
            room_margin = MARGIN_RESET;
        end else begin
            if (i_out_mon.valid && i_out_mon.ready) begin
                if (status_due.size() == 0) begin
                    o_fail_count++;
                    $display("%0t: result with none expected, sample_out %0d fill_level %0d",
                             $time, $signed(i_out_mon.sample_out), i_out_mon.fill_level);
                end else begin
                    want = status_due.pop_front();
                    check_field("sample_out", $signed(want.sample_out),
                                $signed(i_out_mon.sample_out));
                    check_field("sample_from_ring", want.from_ring,
                                i_out_mon.sample_from_ring);
                    check_field("fill_level", want.fill_level, i_out_mon.fill_level);
                    check_field("room_low", want.room_low, i_out_mon.room_low);
                    check_field("receiving", want.receiving, i_out_mon.receiving);
                end
            end
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_GAIN:   gain_q14    = i_cfg_data[GAIN_W-1:0];
                    CFG_IDLE:   idle_limit  = i_cfg_data[IDLE_W-1:0];
                    CFG_MARGIN: room_margin = i_cfg_data[MARGIN_W-1:0];
                    default: ;
                endcase
            end
            if (i_in_mon.valid && i_in_mon.ready)
                status_due.push_back(step_ring_model(i_in_mon.func, i_in_mon.data_byte,
                                                     i_in_mon.block_end));
        end
        o_pending <= status_due.size();
    end

endmodule

// ===== dv/audio_jitter_ring_with_gain_unit_tb.sv =====
// Testbench top for the audio jitter ring: clock, reset, stimulus, register
// writes and the verdict. Depends on ajr_pkg, the channel interfaces, the
// ring unit and ajr_ring_checker.
`timescale 1ns / 1ps

module audio_jitter_ring_with_gain_unit_tb;
    import ajr_pkg::*;

    localparam logic [FUNC_W-1:0] FUNC_SPARE = 2'd3;
    localparam int SETTLE_CYCLES  = 8;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int PHASE_ITEMS    = 100;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_idx;
    logic [CFG_DATA_W-1:0] cfg_data;

    int fail_count;
    int pending;
    int quiet_cycles;
    int src_gap_pct;
    int snk_stall_pct;
    int items_sent;

    ajr_in_if  in_ch ();
    ajr_out_if out_ch ();

    audio_jitter_ring_with_gain_unit DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in       (in_ch),
        .o_out      (out_ch),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data)
    );

    ajr_ring_checker u_ring_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_mon     (in_ch),
        .i_out_mon    (out_ch),
        .i_cfg_we     (cfg_we),
        .i_cfg_idx    (cfg_idx),
        .i_cfg_data   (cfg_data),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    // 12 ns clock
    always begin
        i_clk = 1'b0;
        #6;
        i_clk = 1'b1;
        #6;
    end

    // Stall the result side at random
    always @(posedge i_clk) begin
        out_ch.ready <= ($urandom_range(99) >= snk_stall_pct);
    end

    // Abort when no transaction moves on either channel for too long
    always @(posedge i_clk) begin
        if (!i_rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // Offer one item after a random gap; hold valid until it is taken
    task automatic send_item(input logic [FUNC_W-1:0] f, input logic [BYTE_W-1:0] b,
                             input logic e);
        while ($urandom_range(99) < src_gap_pct) begin
            in_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        in_ch.valid     <= 1'b1;
        in_ch.func      <= f;
        in_ch.data_byte <= b;
        in_ch.block_end <= e;
        @(posedge i_clk);
        while (!in_ch.ready)
            @(posedge i_clk);
        items_sent++;
    endtask

    // Four bytes of one stereo frame, little-endian, left sample first
    task automatic push_frame(input logic [31:0] frame);
        for (int k = 0; k < 4; k++)
            send_item(FUNC_PUSH, frame[8*k +: 8], 1'($urandom_range(1)));
    endtask

    // Stop sending, wait out every pending result, then let the unit settle
    task automatic drain();
        in_ch.valid <= 1'b0;
        do
            @(posedge i_clk);
        while (pending != 0);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Write all three registers back to back
    task automatic set_config(input logic [GAIN_W-1:0] gain, input logic [IDLE_W-1:0] idle,
                              input logic [MARGIN_W-1:0] margin);
        cfg_we   <= 1'b1;
        cfg_idx  <= CFG_GAIN;
        cfg_data <= CFG_DATA_W'(gain);
        @(posedge i_clk);
        cfg_idx  <= CFG_IDLE;
        cfg_data <= CFG_DATA_W'(idle);
        @(posedge i_clk);
        cfg_idx  <= CFG_MARGIN;
        cfg_data <= CFG_DATA_W'(margin);
        @(posedge i_clk);
        cfg_we   <= 1'b0;
    endtask

    // Mostly whole frames and pops, with stray bytes, tick runs and spare codes
    task automatic random_traffic(input int n_items, input int pop_pct);
        int target;
        int pick;
        target = items_sent + n_items;
        while (items_sent < target) begin
            pick = $urandom_range(99);
            if (pick < pop_pct) begin
                send_item(FUNC_POP, BYTE_W'($urandom()), $urandom_range(3) == 0);
            end else begin
                pick = $urandom_range(99);
                if (pick < 70)
                    push_frame($urandom());
                else if (pick < 82)
                    send_item(FUNC_PUSH, BYTE_W'($urandom()), 1'($urandom_range(1)));
                else if (pick < 97)
                    repeat ($urandom_range(1, 6))
                        send_item(FUNC_TICK, BYTE_W'($urandom()), 1'($urandom_range(1)));
                else
                    send_item(FUNC_SPARE, BYTE_W'($urandom()), 1'($urandom_range(1)));
            end
        end
    endtask

    initial begin
        logic [GAIN_W-1:0]   gain;
        logic [IDLE_W-1:0]   idle;
        logic [MARGIN_W-1:0] margin;

        // Known levels before the first edge
        i_rst_n         = 1'b0;
        cfg_we          = 1'b0;
        cfg_idx         = CFG_GAIN;
        cfg_data        = '0;
        in_ch.valid     = 1'b0;
        in_ch.func      = FUNC_PUSH;
        in_ch.data_byte = '0;
        in_ch.block_end = 1'b0;
        out_ch.ready    = 1'b0;
        quiet_cycles    = 0;
        items_sent      = 0;
        src_gap_pct     = 15;
        snk_stall_pct   = 88;

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Reset settings: status items, empty pops with and without keepalive
        send_item(FUNC_TICK, 8'h00, 1'b0);
        send_item(FUNC_SPARE, 8'hFF, 1'b1);
        send_item(FUNC_POP, 8'h00, 1'b0);
        send_item(FUNC_POP, 8'hFF, 1'b1);
        // Extreme samples: -32768 / 32767, then -1 / 1
        push_frame(32'h7FFF_8000);
        push_frame(32'h0001_FFFF);
        send_item(FUNC_POP, 8'h00, 1'b0);
        send_item(FUNC_POP, 8'h00, 1'b1);
        send_item(FUNC_POP, 8'h00, 1'b0);
        send_item(FUNC_POP, 8'h00, 1'b1);

        // Maximum gain saturates, zero idle limit clears on the first tick,
        // full margin holds room_low high
        drain();
        set_config(GAIN_MAX, 16'd0, MARGIN_W'(RING_DEPTH));
        push_frame(32'h7FFF_8000);
        send_item(FUNC_TICK, 8'h5A, 1'b0);
        send_item(FUNC_POP, 8'hA5, 1'b0);
        send_item(FUNC_POP, 8'h00, 1'b1);
        send_item(FUNC_POP, 8'h00, 1'b0);

        // Random phases across idling patterns and register settings
        for (int ph = 0; ph < 6; ph++) begin
            case (ph / 2)
                0: begin
                    src_gap_pct   = 15;
                    snk_stall_pct = 88;
                end
                1: begin
                    src_gap_pct   = 88;
                    snk_stall_pct = 15;
                end
                default: begin
                    src_gap_pct   = 0;
                    snk_stall_pct = 0;
                end
            endcase
            case (ph)
                0: begin
                    gain   = GAIN_RESET;
                    idle   = 16'd3;
                    margin = MARGIN_W'(RING_DEPTH - 24);
                end
                1: begin
                    gain   = 16'hFFFF;
                    idle   = 16'd1;
                    margin = '0;
                end
                2: begin
                    gain   = '0;
                    idle   = QUIET_MAX;
                    margin = MARGIN_W'(RING_DEPTH);
                end
                3: begin
                    gain   = GAIN_W'($urandom());
                    idle   = IDLE_W'($urandom_range(1, 8));
                    margin = MARGIN_W'(RING_DEPTH - $urandom_range(0, 64));
                end
                4: begin
                    gain   = GAIN_MAX;
                    idle   = 16'd2;
                    margin = MARGIN_W'($urandom_range(0, RING_DEPTH));
                end
                default: begin
                    gain   = GAIN_W'($urandom());
                    idle   = IDLE_W'($urandom_range(1, 8));
                    margin = MARGIN_W'(RING_DEPTH - $urandom_range(0, 200));
                end
            endcase
            drain();
            set_config(gain, idle, margin);
            random_traffic(PHASE_ITEMS, (ph % 2 == 1) ? 60 : 25);
        end

        drain();
        repeat (20) @(posedge i_clk);
        if (fail_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

// ===== files.f =====
+incdir+rtl/core
rtl/core/ajr_pkg.sv
rtl/core/ajr_in_if.sv
rtl/core/ajr_out_if.sv
rtl/core/ajr_front.sv
rtl/core/ajr_queue.sv
rtl/core/ajr_back.sv
rtl/core/audio_jitter_ring_with_gain_unit.sv
dv/ajr_ring_checker.sv
dv/audio_jitter_ring_with_gain_unit_tb.sv
